FILE: hw/rtl/hjdd_pkg.sv
// headset jack detect debounce: shared types, register indexes and reset constants
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package hjdd_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_DELAY      = 3'd0,
    CFG_BUTTON_DELAY      = 3'd1,
    CFG_ARM_DELAY         = 3'd2,
    CFG_DETECT_INS_LEVEL  = 3'd3,
    CFG_BUTTON_DOWN_LEVEL = 3'd4
  } cfg_idx_t;

  // register reset values
  localparam logic [CFG_W-1:0] DETECT_DELAY_RST = 16'd300;
  localparam logic [CFG_W-1:0] BUTTON_DELAY_RST = 16'd120;
  localparam logic [CFG_W-1:0] ARM_DELAY_RST    = 16'd2000;
  localparam logic             DETECT_INS_RST   = 1'b0;
  localparam logic             BUTTON_DOWN_RST  = 1'b1;

  typedef enum logic [1:0] {
    DET_IDLE = 2'd0,
    DET_WAIT = 2'd1,
    DET_HOLD = 2'd2
  } det_phase_t;

  typedef enum logic {
    BTN_IDLE = 1'b0,
    BTN_WAIT = 1'b1
  } btn_phase_t;

  typedef struct packed {
    logic detect_level;
    logic button_level;
  } in_item_t;

  typedef struct packed {
    logic headset_present;
    logic headset_changed;
    logic mic_bias_on;
    logic button_down;
    logic button_changed;
  } out_item_t;

  // what the detect side hands to the button side for the same tick
  typedef struct packed {
    logic presence;       // presence after this tick
    logic changed;        // presence changed this tick
    logic arm_button;     // hold-off over, button re-armed
    logic disarm_button;  // removal, button disarmed
    logic dsample;        // raw detect pin shows inserted
  } det_evt_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hjdd_if.sv
// headset jack detect debounce: valid/ready channel interfaces for tick and result items
// depends on hjdd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hjdd_in_if;
  logic               valid;
  logic               ready;
  hjdd_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface hjdd_out_if;
  logic                valid;
  logic                ready;
  hjdd_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hjdd_detect.sv
// headset jack detect debounce: jack-detect sampler, presence and arm hold-off
// depends on hjdd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hjdd_detect #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic                  detect_level,
  input  wire logic                  inserted_level,
  input  wire logic [TIMER_BITS-1:0] load_detect,
  input  wire logic [TIMER_BITS-1:0] load_arm,
  output hjdd_pkg::det_evt_t         evt
);

  localparam logic [TIMER_BITS-1:0] T_ONE = TIMER_BITS'(1);

  hjdd_pkg::det_phase_t    phase_r, phase_nxt;
  logic [TIMER_BITS-1:0]   timer_r, timer_nxt;
  logic                    prev_pin_r;
  logic                    first_r, first_nxt;
  logic                    presence_r, presence_nxt;
  logic                    armed_r, armed_nxt;

  logic dedge, dsample, fire;

  assign dedge   = detect_level ^ prev_pin_r;
  assign dsample = (detect_level == inserted_level);
  assign fire    = (timer_r <= T_ONE);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      hjdd_pkg::DET_WAIT: begin
        if (fire) begin
          if (dsample != first_r) begin
            phase_nxt = hjdd_pkg::DET_WAIT;
          end else if (dsample != presence_r && dsample) begin
            phase_nxt = hjdd_pkg::DET_HOLD;
          end else begin
            phase_nxt = hjdd_pkg::DET_IDLE;
          end
        end
      end
      hjdd_pkg::DET_HOLD: begin
        if (fire) phase_nxt = hjdd_pkg::DET_IDLE;
      end
      hjdd_pkg::DET_IDLE: begin
        phase_nxt = (dedge && armed_r) ? hjdd_pkg::DET_WAIT : hjdd_pkg::DET_IDLE;
      end
      default: begin
        phase_nxt = (dedge && armed_r) ? hjdd_pkg::DET_WAIT : hjdd_pkg::DET_IDLE;
      end
    endcase
  end

  // datapath and events
  always_comb begin
    timer_nxt         = timer_r;
    first_nxt         = first_r;
    presence_nxt      = presence_r;
    armed_nxt         = armed_r;
    evt.changed       = 1'b0;
    evt.arm_button    = 1'b0;
    evt.disarm_button = 1'b0;
    case (phase_r)
      hjdd_pkg::DET_WAIT: begin
        if (!fire) begin
          timer_nxt = timer_r - T_ONE;
        end else if (dsample != first_r) begin
          // mismatch restarts the wait from the new sample
          first_nxt = dsample;
          timer_nxt = load_detect;
        end else if (dsample != presence_r) begin
          presence_nxt = dsample;
          evt.changed  = 1'b1;
          if (dsample) begin
            timer_nxt = load_arm;
          end else begin
            timer_nxt         = '0;
            evt.disarm_button = 1'b1;
            armed_nxt         = 1'b1;
          end
        end else begin
          timer_nxt = '0;
          armed_nxt = 1'b1;
        end
      end
      hjdd_pkg::DET_HOLD: begin
        if (fire) begin
          timer_nxt      = '0;
          armed_nxt      = 1'b1;
          evt.arm_button = 1'b1;
        end else begin
          timer_nxt = timer_r - T_ONE;
        end
      end
      hjdd_pkg::DET_IDLE: begin
        if (dedge && armed_r) begin
          armed_nxt = 1'b0;
          first_nxt = dsample;
          timer_nxt = load_detect;
        end
      end
      default: begin
        if (dedge && armed_r) begin
          armed_nxt = 1'b0;
          first_nxt = dsample;
          timer_nxt = load_detect;
        end
      end
    endcase
    evt.presence = presence_nxt;
    evt.dsample  = dsample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= hjdd_pkg::DET_IDLE;
      timer_r    <= '0;
      prev_pin_r <= ~hjdd_pkg::DETECT_INS_RST;
      first_r    <= 1'b0;
      presence_r <= 1'b0;
      armed_r    <= 1'b1;
    end else if (step) begin
      phase_r    <= phase_nxt;
      timer_r    <= timer_nxt;
      prev_pin_r <= detect_level;
      first_r    <= first_nxt;
      presence_r <= presence_nxt;
      armed_r    <= armed_nxt;
    end
  end

  // hold-off only runs after an insertion
  a_hold_present: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == hjdd_pkg::DET_HOLD |-> presence_r)
    else $error("detect hold-off without presence");

  // armed exactly while idle
  a_armed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r == (phase_r == hjdd_pkg::DET_IDLE))
    else $error("detect armed flag out of step with phase");

endmodule

`default_nettype wire

FILE: hw/rtl/hjdd_button.sv
// headset jack detect debounce: button sampler and press/release state
// depends on hjdd_pkg; takes the detect events of the same tick
`timescale 1ns / 1ps
`default_nettype none

module hjdd_button #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic                  button_level,
  input  wire logic                  down_level,
  input  wire logic [TIMER_BITS-1:0] load_button,
  input  wire hjdd_pkg::det_evt_t    evt,
  output logic                       pressed_nxt,
  output logic                       changed
);

  localparam logic [TIMER_BITS-1:0] T_ONE = TIMER_BITS'(1);

  hjdd_pkg::btn_phase_t  phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic                  prev_pin_r;
  logic                  first_r, first_nxt;
  logic                  pressed_r;
  logic                  armed_r, armed_nxt;

  logic bedge, bsample, fire, armed_mid, start;

  assign bedge   = button_level ^ prev_pin_r;
  assign bsample = (button_level == down_level);
  assign fire    = (timer_r <= T_ONE);

  // arm state after the detect side has had its say
  assign armed_mid = evt.arm_button ? 1'b1 : (evt.disarm_button ? 1'b0 : armed_r);
  assign start     = bedge && armed_mid && evt.presence;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      hjdd_pkg::BTN_WAIT: if (fire) phase_nxt = hjdd_pkg::BTN_IDLE;
      hjdd_pkg::BTN_IDLE: phase_nxt = start ? hjdd_pkg::BTN_WAIT : hjdd_pkg::BTN_IDLE;
      default:            phase_nxt = hjdd_pkg::BTN_IDLE;
    endcase
  end

  always_comb begin
    timer_nxt   = timer_r;
    first_nxt   = first_r;
    pressed_nxt = pressed_r;
    armed_nxt   = armed_mid;
    changed     = 1'b0;
    case (phase_r)
      hjdd_pkg::BTN_WAIT: begin
        if (fire) begin
          timer_nxt = '0;
          // second sample only counts while the raw pin still shows a headset
          if (evt.dsample && bsample == first_r && bsample != pressed_r) begin
            pressed_nxt = bsample;
            changed     = 1'b1;
          end
          armed_nxt = evt.presence;
        end else begin
          timer_nxt = timer_r - T_ONE;
        end
      end
      hjdd_pkg::BTN_IDLE: begin
        if (start) begin
          armed_nxt = 1'b0;
          first_nxt = bsample;
          timer_nxt = load_button;
        end
      end
      default: begin
        timer_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= hjdd_pkg::BTN_IDLE;
      timer_r    <= '0;
      prev_pin_r <= ~hjdd_pkg::BUTTON_DOWN_RST;
      first_r    <= 1'b0;
      pressed_r  <= 1'b0;
      armed_r    <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      timer_r    <= timer_nxt;
      prev_pin_r <= button_level;
      first_r    <= first_nxt;
      pressed_r  <= pressed_nxt;
      armed_r    <= armed_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/headset_jack_detect_debounce.sv
// Headset jack detect and button debounce. One item per timer tick carries the raw
// jack-detect and button pin levels; one result item comes back per tick with the
// debounced presence, mic bias enable, button state and change flags. The block takes
// one item per clock when the result side keeps up. An item is caught in an input
// register; once the result slot is free, both debounce machines update and the result
// lands in an output register on the same clock.
// out_ch.ready reaches in_ch.ready through one gate, so the two registers act as a
// two-deep pipeline that stalls as one. The delay registers are clamped to the timer
// width (TIMER_BITS) and a delay of zero counts as one tick. There is no clearing pass
// after reset. Configuration is written through cfg_we/cfg_idx/cfg_wdata; indexes
// outside the register list are dropped.
// depends on hjdd_pkg, hjdd_if, hjdd_detect, hjdd_button
`timescale 1ns / 1ps
`default_nettype none

module headset_jack_detect_debounce #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [hjdd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [hjdd_pkg::CFG_W-1:0]     cfg_wdata,
  hjdd_in_if.sink                             in_ch,
  hjdd_out_if.source                          out_ch
);

  // configuration registers
  logic [hjdd_pkg::CFG_W-1:0] detect_delay_r;
  logic [hjdd_pkg::CFG_W-1:0] button_delay_r;
  logic [hjdd_pkg::CFG_W-1:0] arm_delay_r;
  logic                       detect_ins_r;
  logic                       button_down_r;

  // pipeline registers
  logic                in_v_r;
  hjdd_pkg::in_item_t  in_item_r;
  logic                out_v_r;
  hjdd_pkg::out_item_t out_item_r, out_item_nxt;

  logic out_free, adv, in_take;

  logic [TIMER_BITS-1:0] load_detect, load_button, load_arm;
  hjdd_pkg::det_evt_t    evt;
  logic                  pressed_nxt, btn_changed;

  // clamp a delay register into the timer, zero acting as one tick
  function automatic logic [TIMER_BITS-1:0] load_val(input logic [hjdd_pkg::CFG_W-1:0] d);
    logic [TIMER_BITS+hjdd_pkg::CFG_W-1:0] w;
    logic [TIMER_BITS-1:0]                 v;
    w = {{TIMER_BITS{1'b0}}, d};
    if (w > {{hjdd_pkg::CFG_W{1'b0}}, {TIMER_BITS{1'b1}}}) v = '1;
    else v = w[TIMER_BITS-1:0];
    if (v == '0) v = TIMER_BITS'(1);
    return v;
  endfunction

  assign load_detect = load_val(detect_delay_r);
  assign load_button = load_val(button_delay_r);
  assign load_arm    = load_val(arm_delay_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_delay_r <= hjdd_pkg::DETECT_DELAY_RST;
      button_delay_r <= hjdd_pkg::BUTTON_DELAY_RST;
      arm_delay_r    <= hjdd_pkg::ARM_DELAY_RST;
      detect_ins_r   <= hjdd_pkg::DETECT_INS_RST;
      button_down_r  <= hjdd_pkg::BUTTON_DOWN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        hjdd_pkg::CFG_DETECT_DELAY:      detect_delay_r <= cfg_wdata;
        hjdd_pkg::CFG_BUTTON_DELAY:      button_delay_r <= cfg_wdata;
        hjdd_pkg::CFG_ARM_DELAY:         arm_delay_r    <= cfg_wdata;
        hjdd_pkg::CFG_DETECT_INS_LEVEL:  detect_ins_r   <= cfg_wdata[0];
        hjdd_pkg::CFG_BUTTON_DOWN_LEVEL: button_down_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake: the tick in the input register moves on when the result slot is free
  assign out_free    = !out_v_r || out_ch.ready;
  assign adv         = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) in_v_r <= 1'b1;
      else if (adv) in_v_r <= 1'b0;
      if (adv) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_item_r <= in_ch.item;
    if (adv) out_item_r <= out_item_nxt;
  end

  // jack detect side, runs first within a tick
  hjdd_detect #(.TIMER_BITS(TIMER_BITS)) u_detect (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (adv),
    .detect_level   (in_item_r.detect_level),
    .inserted_level (detect_ins_r),
    .load_detect    (load_detect),
    .load_arm       (load_arm),
    .evt            (evt)
  );

  // button side sees the presence and arm changes of the same tick
  hjdd_button #(.TIMER_BITS(TIMER_BITS)) u_button (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .button_level (in_item_r.button_level),
    .down_level   (button_down_r),
    .load_button  (load_button),
    .evt          (evt),
    .pressed_nxt  (pressed_nxt),
    .changed      (btn_changed)
  );

  always_comb begin
    out_item_nxt.headset_present = evt.presence;
    out_item_nxt.headset_changed = evt.changed;
    out_item_nxt.mic_bias_on     = evt.presence;
    out_item_nxt.button_down     = pressed_nxt;
    out_item_nxt.button_changed  = btn_changed;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.item  = out_item_r;

  // every processed tick yields a result next cycle
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("processed tick left no result");

  // a blocked tick stays put in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !out_free) |=> (in_v_r && $stable(in_item_r)))
    else $error("stalled tick lost or changed");

endmodule

`default_nettype wire
